@@ hdl/rrd_pkg.sv @@
// Package for the RGB565 run-length decoder: phases, status codes, queue entry type.
`default_nettype none
package rrd_pkg;

	// Parser phases: four header bytes, control byte, pixel bytes, final states
	typedef enum logic [3:0] {
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_HDR3,
		PH_CTL,
		PH_RLO,
		PH_RHI,
		PH_LLO,
		PH_LHI,
		PH_DONE,
		PH_EMPTY,
		PH_OVERCAP,
		PH_OVERRUN,
		PH_TRUNC
	} phase_t;

	// Status codes on the result channel
	localparam logic [2:0] ST_RUNNING  = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_OVERCAP  = 3'd3;
	localparam logic [2:0] ST_OVERRUN  = 3'd4;
	localparam logic [2:0] ST_TRUNC    = 3'd5;

	localparam int          CAP_W         = 25;
	localparam logic [24:0] CAP_RESET     = 25'd76800;
	localparam int          RUN_FLAG_BIT  = 7;
	localparam logic [6:0]  RUN_LEN_MASK  = 7'h7F;
	localparam int          QUEUE_DEPTH_DEF = 4;

	// One entry per input byte: a pixel repeated npix times (0 = status only)
	typedef struct packed {
		logic [15:0] pix;
		logic [7:0]  npix;
		logic [2:0]  status;
	} cmd_t;

	function automatic logic [2:0] status_of(input phase_t ph);
		logic [2:0] st;
		case (ph)
			PH_DONE:    st = ST_DONE;
			PH_EMPTY:   st = ST_EMPTY;
			PH_OVERCAP: st = ST_OVERCAP;
			PH_OVERRUN: st = ST_OVERRUN;
			PH_TRUNC:   st = ST_TRUNC;
			default:    st = ST_RUNNING;
		endcase
		return st;
	endfunction

endpackage
`default_nettype wire

@@ hdl/rrd_ifs.sv @@
// Channel interfaces of the decoder: byte input, pixel result output, capacity write.
`default_nettype none
interface rrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;
	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface rrd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] first_pixel;
	logic [15:0] second_pixel;
	logic [1:0]  num_pixels;
	logic [2:0]  status;
	logic        last_of_run;
	modport source (output valid, output first_pixel, output second_pixel,
		output num_pixels, output status, output last_of_run, input ready);
	modport sink (input valid, input first_pixel, input second_pixel,
		input num_pixels, input status, input last_of_run, output ready);
endinterface

interface rrd_cfg_if;
	logic        valid;
	logic        ready;
	logic [24:0] max_pixels;
	modport source (output valid, output max_pixels, input ready);
	modport sink (input valid, input max_pixels, output ready);
endinterface
`default_nettype wire

@@ hdl/rgb565_rle_decoder.sv @@
// Top level of the RGB565 run-length decoder: parser, entry queue and pixel emitter.
//
// Usage: in_ch takes the compressed stream one byte per request, end_of_input
// marking the final byte. The stream opens with a 4-byte little-endian pixel
// count, then control bytes (bit 7 = repeat, bits 6..0 = length - 1) and their
// little-endian pixels. out_ch delivers one result per request: up to two
// pixels, the stream status and a flag on the last result of each byte.
// cfg writes the pixel capacity, always ready; the user must write it while idle, the block does not check.
// Path: a byte passes the entry queue, the working entry and the output register.
// Throughput: the parser takes one byte per cycle while the entry queue has
// room; while out_ch is ready the emitter sends one result per cycle, so a
// repeat run of L pixels holds the emitter for ceil(L/2) results and the
// queue absorbs the bytes meanwhile. A queue entry is loaded into the emitter
// in the cycle its predecessor finishes, so literal data flows at one byte per cycle.
// Reset: parser returns to the first header byte, queue and output empty,
// capacity back to 76800. When out_ch stalls, the output register holds its
// result, the queue fills and in_ch drops ready.
`default_nettype none
module rgb565_rle_decoder
	import rrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rrd_in_if.sink     in_ch,
	rrd_out_if.source  out_ch,
	rrd_cfg_if.sink    cfg
);

	cmd_t push_cmd, pop_cmd;
	logic push, pop, full, not_empty;

	rrd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_full (full),
		.q_push (push),
		.q_cmd  (push_cmd)
	);

	rrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	rrd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_cmd   (pop_cmd),
		.q_pop   (pop),
		.out_ch  (out_ch)
	);

endmodule
`default_nettype wire

@@ hdl/rrd_front.sv @@
// Front end: byte parser that turns each input byte into one queue entry.
`default_nettype none
module rrd_front
	import rrd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	rrd_in_if.sink     in_ch,
	rrd_cfg_if.sink    cfg,
	input  wire logic  q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	phase_t         phase_q, phase_n;
	logic [31:0]    total_q, total_n;
	logic [CAP_W-1:0] done_q, done_n;
	logic [7:0]     run_q, run_n;
	logic [7:0]     lat_q, lat_n;
	logic [CAP_W-1:0] cap_q;
	logic [7:0]     run_len;
	logic [CAP_W:0] run_end;
	logic [7:0]     b;

	assign b = in_ch.data_byte;
	assign in_ch.ready = !q_full;
	assign q_push = in_ch.valid && !q_full;
	assign cfg.ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.max_pixels;
		end
	end

	assign run_len = {1'b0, b[6:0] & RUN_LEN_MASK} + 8'd1;
	assign run_end = {1'b0, done_q} + {{(CAP_W-7){1'b0}}, run_len};

	// parse one byte
	always_comb begin
		phase_n = phase_q;
		total_n = total_q;
		done_n  = done_q;
		run_n   = run_q;
		lat_n   = lat_q;
		q_cmd.pix  = 16'd0;
		q_cmd.npix = 8'd0;
		case (phase_q)
			PH_HDR0: begin
				total_n[7:0] = b;
				phase_n = PH_HDR1;
			end
			PH_HDR1: begin
				total_n[15:8] = b;
				phase_n = PH_HDR2;
			end
			PH_HDR2: begin
				total_n[23:16] = b;
				phase_n = PH_HDR3;
			end
			PH_HDR3: begin
				total_n[31:24] = b;
				if (total_n == 32'd0) begin
					phase_n = PH_EMPTY;
				end else if (total_n > {{(32-CAP_W){1'b0}}, cap_q}) begin
					phase_n = PH_OVERCAP;
				end else begin
					phase_n = PH_CTL;
				end
			end
			PH_CTL: begin
				run_n = run_len;
				if ({{(31-CAP_W){1'b0}}, run_end} > total_q) begin
					phase_n = PH_OVERRUN;
				end else if (b[RUN_FLAG_BIT]) begin
					phase_n = PH_RLO;
				end else begin
					phase_n = PH_LLO;
				end
			end
			PH_RLO: begin
				lat_n = b;
				phase_n = PH_RHI;
			end
			PH_RHI: begin
				q_cmd.pix  = {b, lat_q};
				q_cmd.npix = run_q;
				done_n = done_q + {{(CAP_W-8){1'b0}}, run_q};
				run_n  = 8'd0;
				phase_n = ({{(32-CAP_W){1'b0}}, done_n} == total_q) ? PH_DONE : PH_CTL;
			end
			PH_LLO: begin
				lat_n = b;
				phase_n = PH_LHI;
			end
			PH_LHI: begin
				q_cmd.pix  = {b, lat_q};
				q_cmd.npix = 8'd1;
				done_n = done_q + {{(CAP_W-1){1'b0}}, 1'b1};
				run_n  = run_q - 8'd1;
				if (run_n != 8'd0) begin
					phase_n = PH_LLO;
				end else begin
					phase_n = ({{(32-CAP_W){1'b0}}, done_n} == total_q) ? PH_DONE : PH_CTL;
				end
			end
			default: begin
			end
		endcase
		// stream ended before a final status
		if (in_ch.end_of_input && status_of(phase_n) == ST_RUNNING) begin
			phase_n = PH_TRUNC;
		end
		q_cmd.status = status_of(phase_n);
	end

	// parser state; end of stream returns to the header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			total_q <= 32'd0;
			done_q  <= '0;
			run_q   <= 8'd0;
			lat_q   <= 8'd0;
		end else if (q_push) begin
			if (in_ch.end_of_input) begin
				phase_q <= PH_HDR0;
				total_q <= 32'd0;
				done_q  <= '0;
				run_q   <= 8'd0;
				lat_q   <= 8'd0;
			end else begin
				phase_q <= phase_n;
				total_q <= total_n;
				done_q  <= done_n;
				run_q   <= run_n;
				lat_q   <= lat_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/rrd_queue.sv @@
// Small FIFO of parsed entries between the parser and the pixel emitter.
`default_nettype none
module rrd_queue
	import rrd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	output logic       full,
	input  wire logic  pop,
	output cmd_t       pop_cmd,
	output logic       not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign pop_cmd = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/rrd_back.sv @@
// Back end: expands queue entries into pixel-pair results behind an output register.
`default_nettype none
module rrd_back
	import rrd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire cmd_t  q_cmd,
	output logic       q_pop,
	rrd_out_if.source  out_ch
);

	logic        busy_q;
	logic [7:0]  rem_q, rem_n;
	logic [15:0] pix_q;
	logic [2:0]  status_q;
	logic [1:0]  cnt;
	logic        load_ok, emit, fin;

	logic        valid_q;
	logic [15:0] first_q, second_q;
	logic [1:0]  count_q;
	logic [2:0]  ostat_q;
	logic        last_q;

	assign load_ok = !valid_q || out_ch.ready;
	assign emit = busy_q && load_ok;

	// split remaining pixels into pairs
	always_comb begin
		cnt   = 2'd0;
		rem_n = rem_q;
		if (rem_q >= 8'd2) begin
			cnt   = 2'd2;
			rem_n = rem_q - 8'd2;
		end else if (rem_q == 8'd1) begin
			cnt   = 2'd1;
			rem_n = 8'd0;
		end
	end

	assign fin = emit && (rem_n == 8'd0);
	assign q_pop = q_valid && (!busy_q || fin);

	// working entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= 8'd0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			rem_q  <= q_cmd.npix;
		end else if (fin) begin
			busy_q <= 1'b0;
			rem_q  <= 8'd0;
		end else if (emit) begin
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_q    <= q_cmd.pix;
			status_q <= q_cmd.status;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			first_q  <= (cnt != 2'd0) ? pix_q : 16'd0;
			second_q <= (cnt == 2'd2) ? pix_q : 16'd0;
			count_q  <= cnt;
			ostat_q  <= status_q;
			last_q   <= (rem_n == 8'd0);
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.first_pixel  = first_q;
	assign out_ch.second_pixel = second_q;
	assign out_ch.num_pixels   = count_q;
	assign out_ch.status       = ostat_q;
	assign out_ch.last_of_run  = last_q;

endmodule
`default_nettype wire
